### rtl/silhouette_edge_extruder_macros.svh
// Assertion macros shared by the silhouette edge extruder RTL.
`ifndef SILHOUETTE_EDGE_EXTRUDER_MACROS_SVH
`define SILHOUETTE_EDGE_EXTRUDER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define SEE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SEE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEE_ASSERT(label, clk, rst, prop, msg)
`define SEE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/see_pkg.sv
// Types, constants and the emit order table of the silhouette edge extruder.
`timescale 1ns / 1ps
`default_nettype none

package see_pkg;

  // Configuration port.
  localparam int REG_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z = 2'd2;

  // Field widths.
  localparam int INDEX_BITS_DEF = 16;
  localparam int VTX_IN_W       = 16;
  localparam int NORM_W         = 16;
  localparam int OFFS_W         = 32;
  localparam int OUT_IDX_W      = 17;
  localparam int IN_TDATA_W     = 192;
  localparam int OUT_TDATA_W    = 24;

  // Arithmetic widths of the plane distance.
  localparam int PROD_W  = NORM_W + REG_W;
  localparam int PSUM_W  = PROD_W + 1;
  localparam int DIST_W  = PROD_W + 2;
  localparam int OFFS_SH = 15;

  // Output sequencer.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] FIRST_STEP = 3'd0;
  localparam logic [STEP_W-1:0] LAST_STEP  = 3'd5;

  // One emitted index: which vertex of the edge, and whether it is the far copy.
  typedef struct packed {
    logic use_second;
    logic odd;
  } pick_t;

  // Emit order of the two extrusion triangles for each winding.
  function automatic pick_t seq_pick(input logic front, input logic [STEP_W-1:0] step);
    pick_t p;
    p = '{use_second: 1'b0, odd: 1'b0};
    if (front) begin
      case (step)
        3'd0: p = '{use_second: 1'b0, odd: 1'b0};
        3'd1: p = '{use_second: 1'b0, odd: 1'b1};
        3'd2: p = '{use_second: 1'b1, odd: 1'b0};
        3'd3: p = '{use_second: 1'b1, odd: 1'b0};
        3'd4: p = '{use_second: 1'b0, odd: 1'b1};
        3'd5: p = '{use_second: 1'b1, odd: 1'b1};
        default: p = '{use_second: 1'b0, odd: 1'b0};
      endcase
    end else begin
      case (step)
        3'd0: p = '{use_second: 1'b0, odd: 1'b0};
        3'd1: p = '{use_second: 1'b1, odd: 1'b0};
        3'd2: p = '{use_second: 1'b0, odd: 1'b1};
        3'd3: p = '{use_second: 1'b1, odd: 1'b0};
        3'd4: p = '{use_second: 1'b1, odd: 1'b1};
        3'd5: p = '{use_second: 1'b0, odd: 1'b1};
        default: p = '{use_second: 1'b0, odd: 1'b0};
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/silhouette_edge_extruder.sv
// Silhouette edge extruder: plane distance pipeline and extrusion index sequencer.
//
// Usage: the light position is written through cfg_we / cfg_index / cfg_data
// (index 0 = x, 1 = y, 2 = z, signed Q16.16) while the block is idle.
// Each beat on the s_axis channel carries one mesh edge: two vertex indices
// and the planes of its two faces. The light's signed distance to each plane
// is found in a three-stage pipeline (multiply, partial add, final add and
// sign). An edge whose two distances have strictly opposite signs is a
// silhouette edge and yields six beats on m_axis, the indices of two
// extrusion triangles, with tlast on the sixth; any other edge yields nothing.
// The first index of an edge is shown by the output sequencer, which the
// edge reaches through stages 1, 2 and 3 after its beat is accepted.
// Throughput: one edge per cycle while edges give no result; a silhouette
// edge holds the single-index output sequencer until its six indices are taken.
// A stalled receiver holds the current index in place; the pipeline keeps
// taking edges until its three stages are full, and then drops tready.
// Reset (rst, synchronous) clears the light position, the pipeline valid
// bits and the sequencer, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "silhouette_edge_extruder_macros.svh"

module silhouette_edge_extruder #(
  parameter int INDEX_BITS = see_pkg::INDEX_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [see_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [see_pkg::REG_W-1:0]        cfg_data,
  // Edge input. tdata from bit 0 up: first_vertex, second_vertex, face_a_nx,
  // face_a_ny, face_a_nz, face_a_offset, face_b_nx, face_b_ny, face_b_nz,
  // face_b_offset.
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [see_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Index output. tdata from bit 0 up: vertex_index, then zero fill.
  // tlast carries last_of_run.
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [see_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output      logic                             m_axis_tlast
);

  import see_pkg::*;

  // Vertex indices are kept at the narrower of the field and the index width.
  localparam int VB = (INDEX_BITS < VTX_IN_W) ? INDEX_BITS : VTX_IN_W;

  // Light position registers.
  logic signed [REG_W-1:0] light_x;
  logic signed [REG_W-1:0] light_y;
  logic signed [REG_W-1:0] light_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
      light_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_X: light_x <= cfg_data;
        REG_LIGHT_Y: light_y <= cfg_data;
        REG_LIGHT_Z: light_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input field views.
  logic signed [NORM_W-1:0] in_a_nx, in_a_ny, in_a_nz;
  logic signed [NORM_W-1:0] in_b_nx, in_b_ny, in_b_nz;
  logic signed [OFFS_W-1:0] in_a_off, in_b_off;

  assign in_a_nx  = $signed(s_axis_tdata[47:32]);
  assign in_a_ny  = $signed(s_axis_tdata[63:48]);
  assign in_a_nz  = $signed(s_axis_tdata[79:64]);
  assign in_a_off = $signed(s_axis_tdata[111:80]);
  assign in_b_nx  = $signed(s_axis_tdata[127:112]);
  assign in_b_ny  = $signed(s_axis_tdata[143:128]);
  assign in_b_nz  = $signed(s_axis_tdata[159:144]);
  assign in_b_off = $signed(s_axis_tdata[191:160]);

  // Pipeline registers.
  logic                     valid1, valid2, valid3;
  logic                     ready1, ready2, ready3;
  logic [VB-1:0]            v0_1, v1_1, v0_2, v1_2, v0_3, v1_3;
  logic signed [PROD_W-1:0] pax, pay, paz, pbx, pby, pbz;
  logic signed [OFFS_W-1:0] off_a1, off_b1;
  logic signed [PSUM_W-1:0] sa01, sa2o, sb01, sb2o;
  logic                     pos_a, neg_a, pos_b, neg_b;

  // Output sequencer registers.
  logic              out_valid;
  logic [STEP_W-1:0] emit_step;
  logic [VB-1:0]     held_first;
  logic [VB-1:0]     held_second;
  logic              held_front;

  // Handshake chain: a stage moves on when the stage after it has room.
  logic sil3;
  logic seq_load_ok;
  logic seq_load;

  assign sil3        = (pos_a && neg_b) || (neg_a && pos_b);
  assign seq_load_ok = !out_valid || (m_axis_tready && emit_step == LAST_STEP);
  assign seq_load    = valid3 && sil3 && seq_load_ok;
  assign ready3      = !valid3 || !sil3 || seq_load_ok;
  assign ready2      = !valid2 || ready3;
  assign ready1      = !valid1 || ready2;
  assign s_axis_tready = ready1;

  // Stage 1: the six normal by light products.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      v0_1   <= s_axis_tdata[VB-1:0];
      v1_1   <= s_axis_tdata[VTX_IN_W +: VB];
      pax    <= in_a_nx * light_x;
      pay    <= in_a_ny * light_y;
      paz    <= in_a_nz * light_z;
      pbx    <= in_b_nx * light_x;
      pby    <= in_b_ny * light_y;
      pbz    <= in_b_nz * light_z;
      off_a1 <= in_a_off;
      off_b1 <= in_b_off;
    end
  end

  // Stage 2: pairwise sums, the offset scaled to the product's fraction.
  logic signed [PSUM_W-1:0] off_a_sc, off_b_sc;

  assign off_a_sc = PSUM_W'($signed({off_a1, {OFFS_SH{1'b0}}}));
  assign off_b_sc = PSUM_W'($signed({off_b1, {OFFS_SH{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      v0_2 <= v0_1;
      v1_2 <= v1_1;
      sa01 <= PSUM_W'(pax) + PSUM_W'(pay);
      sa2o <= PSUM_W'(paz) + off_a_sc;
      sb01 <= PSUM_W'(pbx) + PSUM_W'(pby);
      sb2o <= PSUM_W'(pbz) + off_b_sc;
    end
  end

  // Stage 3: full distances, kept only as their signs.
  logic signed [DIST_W-1:0] dist_a, dist_b;

  assign dist_a = DIST_W'(sa01) + DIST_W'(sa2o);
  assign dist_b = DIST_W'(sb01) + DIST_W'(sb2o);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (ready3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      v0_3  <= v0_2;
      v1_3  <= v1_2;
      pos_a <= (dist_a != '0) && !dist_a[DIST_W-1];
      neg_a <= dist_a[DIST_W-1];
      pos_b <= (dist_b != '0) && !dist_b[DIST_W-1];
      neg_b <= dist_b[DIST_W-1];
    end
  end

  // Output sequencer: loads a silhouette edge and walks its six indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      emit_step   <= FIRST_STEP;
      held_first  <= '0;
      held_second <= '0;
      held_front  <= 1'b0;
    end else if (seq_load) begin
      out_valid   <= 1'b1;
      emit_step   <= FIRST_STEP;
      held_first  <= v0_3;
      held_second <= v1_3;
      held_front  <= pos_a;
    end else if (out_valid && m_axis_tready) begin
      if (emit_step == LAST_STEP) begin
        out_valid <= 1'b0;
        emit_step <= FIRST_STEP;
      end else begin
        emit_step <= emit_step + 1'b1;
      end
    end
  end

  // Index of the current beat: twice the chosen vertex, plus one for the far copy.
  pick_t       pick;
  logic [VB:0] out_idx;

  assign pick    = seq_pick(held_front, emit_step);
  assign out_idx = {(pick.use_second ? held_second : held_first), pick.odd};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_idx);
  assign m_axis_tlast  = (emit_step == LAST_STEP);

  // Checks on the sequencer and the stall chain.
  `SEE_ASSERT(a_step_range, clk, rst, out_valid |-> (emit_step <= LAST_STEP), "emit step beyond last index")
  `SEE_ASSERT(a_idle_step, clk, rst, !out_valid |-> (emit_step == FIRST_STEP), "idle sequencer not at first step")
  `SEE_ASSERT(a_stall_hold, clk, rst, (out_valid && !m_axis_tready) |=> (out_valid && $stable(emit_step)), "stalled sequencer moved")
  `SEE_ASSERT(a_stall_cause, clk, rst, (valid3 && !ready3) |-> out_valid, "pipeline stalled with idle sequencer")
  `SEE_ASSERT(a_run_end, clk, rst, (out_valid && m_axis_tready && m_axis_tlast && !seq_load) |=> !out_valid, "sequencer ran past sixth index")

endmodule

`default_nettype wire
